// ----- hdl/ulbp_pkg.sv -----
// Shared types, constants and the uniform pattern table of the LBP pixel coder.
package ulbp_pkg;

    localparam int MAX_WIDTH_DEF = 2048;

    localparam int PIXEL_W  = 8;
    localparam int CODE_W   = 6;
    localparam int PAT_W    = 8;
    localparam int ROW_W    = 16;
    localparam int COL_W    = 11;
    localparam int IMG_W_W  = 12;
    localparam int IMG_H_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [IMG_W_W-1:0] IMG_W_RESET = 12'd640;
    localparam logic [IMG_H_W-1:0] IMG_H_RESET = 16'd480;
    localparam int MIN_DIM = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [CODE_W-1:0] uniform_code;
        logic [PAT_W-1:0]  raw_pattern;
        logic [ROW_W-1:0]  center_row;
        logic [COL_W-1:0]  center_col;
        logic              frame_last;
    } t_result;

    typedef logic [255:0][CODE_W-1:0] t_umap;

    function automatic t_umap build_umap();
        t_umap       m;
        int unsigned nxt;
        int unsigned trans;
        logic [7:0]  p;
        logic [7:0]  x;
        nxt = 1;
        for (int i = 0; i < 256; i++) begin
            p = 8'(i);
            x = p ^ {p[0], p[7:1]};
            trans = 0;
            for (int k = 0; k < 8; k++) begin
                trans = trans + int'(x[k]);
            end
            if (trans <= 2) begin
                m[i] = CODE_W'(nxt);
                nxt = nxt + 1;
            end else begin
                m[i] = '0;
            end
        end
        return m;
    endfunction

    localparam t_umap UNIFORM_MAP = build_umap();

endpackage

// ----- hdl/ulbp_pixel_if.sv -----
// Valid/ready channel that carries one gray pixel word.
interface ulbp_pixel_if
    import ulbp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

// ----- hdl/ulbp_result_if.sv -----
// Valid/ready channel that carries one uniform LBP result word.
interface ulbp_result_if
    import ulbp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] uniform_code;
    logic [PAT_W-1:0]  raw_pattern;
    logic [ROW_W-1:0]  center_row;
    logic [COL_W-1:0]  center_col;
    logic              frame_last;

    modport source (output valid, output uniform_code, output raw_pattern,
                    output center_row, output center_col, output frame_last,
                    input ready);
    modport sink (input valid, input uniform_code, input raw_pattern,
                  input center_row, input center_col, input frame_last,
                  output ready);
endinterface

// ----- hdl/uniform_lbp_pixel_coder.sv -----
// Top level of the uniform LBP pixel coder: line store, 3x3 window and result queue.
//
// Pixels enter on i_pix in raster order, one word per accepted handshake.
// Each interior pixel (row and column at least two) yields one word on o_res
// with the u2 uniform code, the raw 8-bit pattern, the window center position
// and a flag on the last interior result of the frame. Border pixels only
// fill the line store and give no word.
// The two previous rows live in one RAM entry per column, read when a pixel
// is accepted and written back in the following cycle, so a pixel is
// accepted every clock while the queue has room. A result is registered in
// the write-back stage and then in a three-word queue; when the receiver
// stalls, the queue fills and i_pix.ready drops once the queue and the
// write-back stage together hold three words.
// Reset clears the counters, the window and the queue and loads the default
// geometry of 640 by 480; the line store needs no clearing. The user must write image width and
// height on the configuration port only while no pixel is in flight (not enforced).
module uniform_lbp_pixel_coder
    import ulbp_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ulbp_pixel_if.sink            i_pix,
    ulbp_result_if.source         o_res
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > IMG_W_W) ? $clog2(MAX_WIDTH + 1) : IMG_W_W;
    localparam int QDEPTH = 3;

    logic [IMG_W_W-1:0] r_width;
    logic [IMG_H_W-1:0] r_height;
    logic [CW-1:0]      r_col;
    logic [ROW_W-1:0]   r_row;

    logic               r_s2_valid;
    logic [PIXEL_W-1:0] r_s2_pixel;
    logic [CW-1:0]      r_s2_col;
    logic [ROW_W-1:0]   r_s2_row;
    logic               r_s2_emit;
    logic               r_s2_last;

    logic [PIXEL_W-1:0] r_win [6];

    t_result r_queue [QDEPTH];
    logic [1:0] r_wptr;
    logic [1:0] r_rptr;
    logic [1:0] r_cnt;

    logic [WW-1:0]      w_eff;
    logic [IMG_H_W-1:0] h_eff;
    logic [WW-1:0]      col_p1;
    logic [ROW_W:0]     row_p1;
    logic               col_wrap;
    logic               row_wrap;
    logic               accept;
    logic [CW-1:0]      n_col;
    logic [ROW_W-1:0]   n_row;

    logic [2*PIXEL_W-1:0] rdata;
    logic [PIXEL_W-1:0]   top;
    logic [PIXEL_W-1:0]   mid;
    logic [PIXEL_W-1:0]   center;
    logic [PIXEL_W-1:0]   nb [8];
    logic [PAT_W-1:0]     pattern;
    logic [CW-1:0]        col_m1;
    t_result              result;
    logic                 push;
    logic                 pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= IMG_W_RESET;
            r_height <= IMG_H_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[IMG_W_W-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[IMG_H_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (WW'(r_width) < WW'(MIN_DIM)) begin
            w_eff = WW'(MIN_DIM);
        end else if (WW'(r_width) > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
        h_eff    = (r_height < IMG_H_W'(MIN_DIM)) ? IMG_H_W'(MIN_DIM) : r_height;
        col_p1   = WW'(r_col) + WW'(1);
        row_p1   = {1'b0, r_row} + (ROW_W + 1)'(1);
        col_wrap = col_p1 >= w_eff;
        row_wrap = row_p1 >= {1'b0, h_eff};
        n_col    = col_wrap ? '0 : col_p1[CW-1:0];
        if (!col_wrap) begin
            n_row = r_row;
        end else if (row_wrap) begin
            n_row = '0;
        end else begin
            n_row = row_p1[ROW_W-1:0];
        end
    end

    assign i_pix.ready = (3'(r_cnt) + 3'(r_s2_valid)) < 3'(QDEPTH);
    assign accept      = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2_pixel <= i_pix.pixel;
            r_s2_col   <= r_col;
            r_s2_row   <= r_row;
            r_s2_emit  <= (r_row >= ROW_W'(2)) && (r_col >= CW'(2));
            r_s2_last  <= col_wrap && row_wrap;
        end
    end

    ulbp_ram #(
        .WIDTH (2 * PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s2_valid),
        .i_waddr (r_s2_col),
        .i_wdata ({r_s2_pixel, mid}),
        .i_raddr (r_col),
        .o_rdata (rdata)
    );

    assign top    = rdata[PIXEL_W-1:0];
    assign mid    = rdata[2*PIXEL_W-1:PIXEL_W];
    assign center = r_win[1];

    always_comb begin
        nb[0] = r_win[4];
        nb[1] = r_win[5];
        nb[2] = r_win[2];
        nb[3] = r_s2_pixel;
        nb[4] = mid;
        nb[5] = top;
        nb[6] = r_win[0];
        nb[7] = r_win[3];
        for (int k = 0; k < 8; k++) begin
            pattern[k] = nb[k] >= center;
        end
        col_m1              = r_s2_col - CW'(1);
        result.uniform_code = UNIFORM_MAP[pattern];
        result.raw_pattern  = pattern;
        result.center_row   = r_s2_row - ROW_W'(1);
        result.center_col   = COL_W'(col_m1);
        result.frame_last   = r_s2_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_s2_valid) begin
            r_win[3] <= r_win[0];
            r_win[4] <= r_win[1];
            r_win[5] <= r_win[2];
            r_win[0] <= top;
            r_win[1] <= mid;
            r_win[2] <= r_s2_pixel;
        end
    end

    assign push = r_s2_valid && r_s2_emit;
    assign pop  = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == 2'(QDEPTH - 1)) ? '0 : r_wptr + 2'd1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == 2'(QDEPTH - 1)) ? '0 : r_rptr + 2'd1;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wptr] <= result;
        end
    end

    assign o_res.valid        = r_cnt != 2'd0;
    assign o_res.uniform_code = r_queue[r_rptr].uniform_code;
    assign o_res.raw_pattern  = r_queue[r_rptr].raw_pattern;
    assign o_res.center_row   = r_queue[r_rptr].center_row;
    assign o_res.center_col   = r_queue[r_rptr].center_col;
    assign o_res.frame_last   = r_queue[r_rptr].frame_last;

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |-> (r_cnt != 2'(QDEPTH)))
        else $error("result queue overflow");

    a_queue_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (r_cnt != 2'd0))
        else $error("result queue underflow");

    a_ram_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_s2_valid) |-> (r_col != r_s2_col))
        else $error("line store read and write hit the same column");

    a_frame_end_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_last) |-> (r_col == '0 && r_row == '0))
        else $error("counters did not wrap at frame end");

endmodule

// ----- hdl/ulbp_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module ulbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
